// File: design/ecpt_pkg.sv
// shared constants, codes and control/status types for the event channel port table
// no dependencies; imported by ecpt_ctrl, ecpt_dp, event_channel_port_table and the test files
package ecpt_pkg;

    localparam int NUM_PORTS = 1024;
    localparam int NUM_VCPUS = 16;

    // port table rows: several ports share one memory word
    localparam int ROW_PORTS = 32;
    localparam int NUM_ROWS  = NUM_PORTS / ROW_PORTS;
    localparam int IDX_W     = $clog2(NUM_PORTS);
    localparam int COL_W     = $clog2(ROW_PORTS);
    localparam int ROW_W     = IDX_W - COL_W;
    localparam int SLOT_W    = 3;
    localparam int ROW_DW    = ROW_PORTS * SLOT_W;

    // field widths
    localparam int CMD_W   = 3;
    localparam int PORT_W  = 10;
    localparam int VCPU_W  = 4;
    localparam int DOM_W   = 16;
    localparam int TOK_W   = 64;
    localparam int STAT_W  = 3;
    localparam int IN_DW   = 120;
    localparam int OUT_DW  = 88;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BIND    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NOTIFY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd5;

    localparam logic [STAT_W-1:0] RC_OK      = 3'd0;
    localparam logic [STAT_W-1:0] RC_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] RC_NOSPACE = 3'd2;
    localparam logic [STAT_W-1:0] RC_NOPERM  = 3'd3;
    localparam logic [STAT_W-1:0] RC_DYING   = 3'd4;

    typedef enum logic [1:0] {
        PS_FREE     = 2'd0,
        PS_RESERVED = 2'd1,
        PS_UNBOUND  = 2'd2,
        PS_HOST     = 2'd3
    } t_pstate;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DSTR_RD,
        ST_DSTR_WR,
        ST_ACC_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              take;
        logic              clr_wr;
        logic              cnt_rst;
        logic              cnt_inc;
        logic              row_rd;
        logic              acc_rd;
        logic              scan_chk;
        logic              dstr_wr;
        logic              acc_exec;
        logic              res_set;
        logic [STAT_W-1:0] res_code;
        logic              out_load;
    } t_dp_ctrl;

    typedef struct packed {
        logic             in_valid;
        logic [CMD_W-1:0] cmd;
        logic             dying;
        logic             vcpu_bad;
        logic             scan_hit;
        logic             last_row;
        logic             out_free;
    } t_dp_stat;

endpackage

// File: design/event_channel_port_table.sv
// event channel port table, top level: ecpt_ctrl sequencer plus ecpt_dp datapath
// a taken word is decided, then bind, free, notify and query read the table and execute;
//   rejected commands go straight to the result; allocate and destroy walk the table by rows
// one word at a time, taken once the previous result is in the output register, which
//   waits while the output register is still full; each step of a row walk reads a row
//   and then checks or writes it; reset first runs a clearing pass over every row
module event_channel_port_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wen,
    input  logic                         i_cfg_wdata,  // domain_dying
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // cmd[2:0], port[12:3], vcpu[16:13], remote_domain[32:17], caller_domain[48:33],
    // caller_privileged[49], host_token[113:50], zero fill
    input  logic [ecpt_pkg::IN_DW-1:0]   i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // status[2:0], port_out[12:3], signal_valid[13], signal_vcpu[17:14],
    // token_out[81:18], zero fill
    output logic [ecpt_pkg::OUT_DW-1:0]  o_m_tdata
);
    import ecpt_pkg::*;

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    ecpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    ecpt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_stat      (stat),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    assign o_s_tready = ctrl.take;

endmodule

// File: design/ecpt_ctrl.sv
// controller state machine for the event channel port table
// sequences clearing, scans, destroy sweeps and table accesses; uses ecpt_pkg
module ecpt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ecpt_pkg::t_dp_stat i_stat,
    output ecpt_pkg::t_dp_ctrl o_ctrl
);
    import ecpt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.last_row) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_stat.in_valid) n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (i_stat.cmd == CMD_ALLOC) begin
                    n_state = (i_stat.dying || i_stat.vcpu_bad) ? ST_DONE : ST_SCAN_RD;
                end else if (i_stat.cmd == CMD_DESTROY) begin
                    n_state = ST_DSTR_RD;
                end else if (i_stat.cmd > CMD_DESTROY || i_stat.dying) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ACC_EXEC;
                end
            end
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                n_state = (i_stat.scan_hit || i_stat.last_row) ? ST_DONE : ST_SCAN_RD;
            end
            ST_DSTR_RD:  n_state = ST_DSTR_WR;
            ST_DSTR_WR: begin
                n_state = i_stat.last_row ? ST_DONE : ST_DSTR_RD;
            end
            ST_ACC_EXEC: n_state = ST_DONE;
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_ctrl.clr_wr  = 1'b1;
                o_ctrl.cnt_inc = !i_stat.last_row;
            end
            ST_IDLE: begin
                o_ctrl.take = 1'b1;
            end
            ST_DECIDE: begin
                if (i_stat.cmd == CMD_ALLOC) begin
                    if (i_stat.dying || i_stat.vcpu_bad) begin
                        o_ctrl.res_set  = 1'b1;
                        o_ctrl.res_code = RC_INVALID;
                    end else begin
                        o_ctrl.cnt_rst = 1'b1;
                    end
                end else if (i_stat.cmd == CMD_DESTROY) begin
                    o_ctrl.cnt_rst = 1'b1;
                end else if (i_stat.cmd > CMD_DESTROY) begin
                    o_ctrl.res_set  = 1'b1;
                    o_ctrl.res_code = RC_INVALID;
                end else if (i_stat.dying) begin
                    o_ctrl.res_set  = 1'b1;
                    o_ctrl.res_code = RC_DYING;
                end else begin
                    o_ctrl.acc_rd = 1'b1;
                end
            end
            ST_SCAN_RD, ST_DSTR_RD: begin
                o_ctrl.row_rd = 1'b1;
            end
            ST_SCAN_CHK: begin
                o_ctrl.scan_chk = 1'b1;
                if (!i_stat.scan_hit) begin
                    if (i_stat.last_row) begin
                        o_ctrl.res_set  = 1'b1;
                        o_ctrl.res_code = RC_NOSPACE;
                    end else begin
                        o_ctrl.cnt_inc = 1'b1;
                    end
                end
            end
            ST_DSTR_WR: begin
                o_ctrl.dstr_wr = 1'b1;
                if (i_stat.last_row) begin
                    o_ctrl.res_set  = 1'b1;
                    o_ctrl.res_code = RC_OK;
                end else begin
                    o_ctrl.cnt_inc = 1'b1;
                end
            end
            ST_ACC_EXEC: begin
                o_ctrl.acc_exec = 1'b1;
            end
            ST_DONE: begin
                o_ctrl.out_load = i_stat.out_free;
            end
            default: o_ctrl = '0;
        endcase
    end

endmodule

// File: design/ecpt_dp.sv
// datapath of the event channel port table: input capture, port table memories,
// row counter, result and output registers; uses ecpt_pkg, driven by ecpt_ctrl
module ecpt_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ecpt_pkg::t_dp_ctrl           i_ctrl,
    output ecpt_pkg::t_dp_stat           o_stat,
    input  logic                         i_cfg_wen,
    input  logic                         i_cfg_wdata,
    input  logic                         i_s_tvalid,
    input  logic [ecpt_pkg::IN_DW-1:0]   i_s_tdata,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [ecpt_pkg::OUT_DW-1:0]  o_m_tdata
);
    import ecpt_pkg::*;

    localparam int META_W = VCPU_W + DOM_W;

    // port table: per port {owned, state}, packed ROW_PORTS to a word
    logic [ROW_DW-1:0] r_row_mem  [NUM_ROWS];
    logic [META_W-1:0] r_meta_mem [NUM_PORTS];
    logic [TOK_W-1:0]  r_tok_mem  [NUM_PORTS];

    logic [ROW_DW-1:0] r_row_q;
    logic [META_W-1:0] r_meta_q;
    logic [TOK_W-1:0]  r_tok_q;

    logic              r_dying;

    // captured word
    logic [CMD_W-1:0]  r_cmd;
    logic [PORT_W-1:0] r_port;
    logic [VCPU_W-1:0] r_vcpu;
    logic [DOM_W-1:0]  r_rdom;
    logic [DOM_W-1:0]  r_cdom;
    logic              r_priv;
    logic [TOK_W-1:0]  r_tok;

    logic [ROW_W-1:0]  r_cnt;

    logic [STAT_W-1:0] r_res_status;
    logic [PORT_W-1:0] r_res_pout;
    logic              r_res_sv;
    logic [VCPU_W-1:0] r_res_svcpu;
    logic [TOK_W-1:0]  r_res_tout;

    logic              r_m_valid;
    logic [OUT_DW-1:0] r_m_data;

    logic              accept;
    logic              pvalid;
    logic [IDX_W-1:0]  p_idx;
    logic [ROW_W-1:0]  p_row;
    logic [COL_W-1:0]  p_col;
    logic [SLOT_W-1:0] p_slot;
    t_pstate           p_st;
    logic              p_owned;

    logic              hit;
    logic [COL_W-1:0]  hit_col;
    logic [IDX_W-1:0]  hit_idx;
    logic [ROW_DW-1:0] scan_row;
    logic [ROW_DW-1:0] dstr_row;
    logic [ROW_DW-1:0] clr_row;
    logic [ROW_DW-1:0] exec_row;
    logic              exec_row_we;
    logic              exec_tok_we;
    logic [STAT_W-1:0] exec_status;
    logic              exec_sv;
    logic [VCPU_W-1:0] exec_svcpu;
    logic [TOK_W-1:0]  exec_tout;

    logic              row_we;
    logic [ROW_W-1:0]  row_waddr;
    logic [ROW_DW-1:0] row_wdata;
    logic [ROW_W-1:0]  row_raddr;
    logic              row_re;

    assign accept  = i_s_tvalid && i_ctrl.take;
    assign pvalid  = {{(32-PORT_W){1'b0}}, r_port} < 32'(NUM_PORTS);
    assign p_idx   = IDX_W'(r_port);
    assign p_row   = p_idx[IDX_W-1:COL_W];
    assign p_col   = p_idx[COL_W-1:0];
    assign p_slot  = r_row_q[p_col*SLOT_W +: SLOT_W];
    assign p_st    = t_pstate'(p_slot[1:0]);
    assign p_owned = p_slot[2];

    // lowest free slot of the row just read
    always_comb begin
        hit     = 1'b0;
        hit_col = '0;
        for (int i = ROW_PORTS - 1; i >= 0; i--) begin
            if (t_pstate'(r_row_q[i*SLOT_W +: 2]) == PS_FREE) begin
                hit     = 1'b1;
                hit_col = COL_W'(i);
            end
        end
    end

    assign hit_idx = {r_cnt, hit_col};

    always_comb begin
        scan_row = r_row_q;
        scan_row[hit_col*SLOT_W +: SLOT_W] = {1'b1, PS_UNBOUND};
    end

    // destroy: drop ownership and close unbound or host ports
    always_comb begin
        dstr_row = r_row_q;
        for (int i = 0; i < ROW_PORTS; i++) begin
            dstr_row[i*SLOT_W + 2] = 1'b0;
            if (t_pstate'(r_row_q[i*SLOT_W +: 2]) == PS_UNBOUND ||
                t_pstate'(r_row_q[i*SLOT_W +: 2]) == PS_HOST) begin
                dstr_row[i*SLOT_W +: 2] = PS_FREE;
            end
        end
    end

    always_comb begin
        clr_row = '0;
        for (int i = 0; i < ROW_PORTS; i++) begin
            clr_row[i*SLOT_W +: SLOT_W] = {1'b0, PS_FREE};
        end
        // port 0 comes up reserved
        if (r_cnt == '0) begin
            clr_row[SLOT_W-1:0] = {1'b0, PS_RESERVED};
        end
    end

    always_comb begin
        exec_row    = r_row_q;
        exec_row_we = 1'b0;
        exec_tok_we = 1'b0;
        exec_status = RC_OK;
        exec_sv     = 1'b0;
        exec_svcpu  = '0;
        exec_tout   = '0;
        if (r_cmd == CMD_BIND) begin
            if (r_tok == '0) begin
                exec_status = RC_INVALID;
            end else if (!r_priv) begin
                exec_status = RC_NOPERM;
            end else if (!pvalid || p_st != PS_UNBOUND ||
                         r_meta_q[DOM_W-1:0] != r_cdom) begin
                exec_status = RC_INVALID;
            end else begin
                exec_tok_we = 1'b1;
                exec_row_we = 1'b1;
                exec_row[p_col*SLOT_W +: 2] = PS_HOST;
            end
        end else if (!pvalid || !p_owned) begin
            exec_status = RC_INVALID;
        end else if (r_cmd == CMD_FREE) begin
            exec_row_we = 1'b1;
            exec_row[p_col*SLOT_W + 2] = 1'b0;
            if (p_st == PS_UNBOUND || p_st == PS_HOST) begin
                exec_row[p_col*SLOT_W +: 2] = PS_FREE;
            end else begin
                exec_status = RC_INVALID;
            end
        end else if (p_st == PS_HOST) begin
            exec_tout = r_tok_q;
            if (r_cmd == CMD_NOTIFY) begin
                exec_sv    = 1'b1;
                exec_svcpu = r_meta_q[META_W-1:DOM_W];
            end
        end
    end

    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_cnt;
        row_wdata = clr_row;
        if (i_ctrl.clr_wr) begin
            row_we = 1'b1;
        end else if (i_ctrl.scan_chk && hit) begin
            row_we    = 1'b1;
            row_wdata = scan_row;
        end else if (i_ctrl.dstr_wr) begin
            row_we    = 1'b1;
            row_wdata = dstr_row;
        end else if (i_ctrl.acc_exec && exec_row_we) begin
            row_we    = 1'b1;
            row_waddr = p_row;
            row_wdata = exec_row;
        end
    end

    assign row_re    = i_ctrl.row_rd || i_ctrl.acc_rd;
    assign row_raddr = i_ctrl.acc_rd ? p_row : r_cnt;

    always_ff @(posedge i_clk) begin
        if (row_we) r_row_mem[row_waddr] <= row_wdata;
        if (row_re) r_row_q <= r_row_mem[row_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scan_chk && hit) r_meta_mem[hit_idx] <= {r_vcpu, r_rdom};
        if (i_ctrl.acc_rd) r_meta_q <= r_meta_mem[p_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.acc_exec && exec_tok_we) r_tok_mem[p_idx] <= r_tok;
        if (i_ctrl.acc_rd) r_tok_q <= r_tok_mem[p_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dying <= 1'b0;
        end else if (i_cfg_wen) begin
            r_dying <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_s_tdata[2:0];
            r_port <= i_s_tdata[12:3];
            r_vcpu <= i_s_tdata[16:13];
            r_rdom <= i_s_tdata[32:17];
            r_cdom <= i_s_tdata[48:33];
            r_priv <= i_s_tdata[49];
            r_tok  <= i_s_tdata[113:50];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctrl.cnt_rst) begin
            r_cnt <= '0;
        end else if (i_ctrl.cnt_inc) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.res_set) begin
            r_res_status <= i_ctrl.res_code;
            r_res_pout   <= '0;
            r_res_sv     <= 1'b0;
            r_res_svcpu  <= '0;
            r_res_tout   <= '0;
        end else if (i_ctrl.scan_chk && hit) begin
            r_res_status <= RC_OK;
            r_res_pout   <= PORT_W'(hit_idx);
            r_res_sv     <= 1'b0;
            r_res_svcpu  <= '0;
            r_res_tout   <= '0;
        end else if (i_ctrl.acc_exec) begin
            r_res_status <= exec_status;
            r_res_pout   <= '0;
            r_res_sv     <= exec_sv;
            r_res_svcpu  <= exec_svcpu;
            r_res_tout   <= exec_tout;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_ctrl.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            r_m_data <= {6'd0, r_res_tout, r_res_svcpu, r_res_sv, r_res_pout, r_res_status};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    assign o_stat.in_valid = i_s_tvalid;
    assign o_stat.cmd      = r_cmd;
    assign o_stat.dying    = r_dying;
    assign o_stat.vcpu_bad = {{(32-VCPU_W){1'b0}}, r_vcpu} >= 32'(NUM_VCPUS);
    assign o_stat.scan_hit = hit;
    assign o_stat.last_row = r_cnt == ROW_W'(NUM_ROWS - 1);
    assign o_stat.out_free = !r_m_valid || i_m_tready;

endmodule

// File: test/ecpt_result_checker.sv
`timescale 1ns / 1ps
// port table checker: watches the command and result streams and the config port,
// predicts each result from its own copy of the port table; needs ecpt_pkg only
module ecpt_result_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wen,
    input  logic                        i_cfg_wdata,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [ecpt_pkg::IN_DW-1:0]  i_s_tdata,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [ecpt_pkg::OUT_DW-1:0] i_m_tdata,
    output int                          o_errors,
    output int                          o_pending
);
    import ecpt_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PORT_W-1:0] port;
        logic              sig;
        logic [VCPU_W-1:0] vcpu;
        logic [TOK_W-1:0]  token;
    } t_port_result;

    t_pstate          tbl_state [NUM_PORTS];
    logic             tbl_owned [NUM_PORTS];
    logic [VCPU_W-1:0] tbl_vcpu [NUM_PORTS];
    logic [DOM_W-1:0] tbl_peer  [NUM_PORTS];
    logic [TOK_W-1:0] tbl_token [NUM_PORTS];
    logic             dying;
    t_port_result     expected_results [$];

    task automatic clear_table();
        int i;
        for (i = 0; i < NUM_PORTS; i++) begin
            tbl_state[i] = PS_FREE;
            tbl_owned[i] = 1'b0;
            tbl_vcpu[i]  = '0;
            tbl_peer[i]  = '0;
            tbl_token[i] = '0;
        end
        tbl_state[0] = PS_RESERVED;
        dying = 1'b0;
    endtask

    function automatic t_port_result run_port_command(input logic [IN_DW-1:0] w);
        logic [CMD_W-1:0]  cmd;
        logic [PORT_W-1:0] port;
        logic [VCPU_W-1:0] vcpu;
        logic [DOM_W-1:0]  rdom;
        logic [DOM_W-1:0]  cdom;
        logic              priv;
        logic [TOK_W-1:0]  tok;
        t_port_result      r;
        bit                pvalid;
        bit                placed;
        int                p;
        int                i;
        cmd  = w[2:0];
        port = w[12:3];
        vcpu = w[16:13];
        rdom = w[32:17];
        cdom = w[48:33];
        priv = w[49];
        tok  = w[113:50];
        r = '0;
        pvalid = int'(port) < NUM_PORTS;
        p = pvalid ? int'(port) : 0;
        if (cmd == CMD_ALLOC) begin
            if (dying || int'(vcpu) >= NUM_VCPUS) begin
                r.status = RC_INVALID;
            end else begin
                r.status = RC_NOSPACE;
                placed = 0;
                // lowest free port wins
                for (i = 0; i < NUM_PORTS && !placed; i++) begin
                    if (tbl_state[i] == PS_FREE) begin
                        tbl_state[i] = PS_UNBOUND;
                        tbl_owned[i] = 1'b1;
                        tbl_vcpu[i]  = vcpu;
                        tbl_peer[i]  = rdom;
                        r.port       = PORT_W'(i);
                        r.status     = RC_OK;
                        placed       = 1;
                    end
                end
            end
        end else if (cmd == CMD_DESTROY) begin
            // allowed while dying; reserved ports survive
            for (i = 0; i < NUM_PORTS; i++) begin
                tbl_owned[i] = 1'b0;
                if (tbl_state[i] == PS_UNBOUND || tbl_state[i] == PS_HOST) begin
                    tbl_state[i] = PS_FREE;
                    tbl_vcpu[i]  = '0;
                end
            end
        end else if (cmd > CMD_DESTROY) begin
            r.status = RC_INVALID;
        end else if (dying) begin
            r.status = RC_DYING;
        end else if (cmd == CMD_BIND) begin
            if (tok == '0) begin
                r.status = RC_INVALID;
            end else if (!priv) begin
                r.status = RC_NOPERM;
            end else if (!pvalid || tbl_state[p] != PS_UNBOUND || tbl_peer[p] != cdom) begin
                r.status = RC_INVALID;
            end else begin
                tbl_token[p] = tok;
                tbl_state[p] = PS_HOST;
            end
        end else if (!pvalid || !tbl_owned[p]) begin
            r.status = RC_INVALID;
        end else if (cmd == CMD_FREE) begin
            tbl_owned[p] = 1'b0;
            if (tbl_state[p] == PS_UNBOUND || tbl_state[p] == PS_HOST) begin
                tbl_state[p] = PS_FREE;
                tbl_vcpu[p]  = '0;
            end else begin
                r.status = RC_INVALID;
            end
        end else if (cmd == CMD_NOTIFY) begin
            if (tbl_state[p] == PS_HOST) begin
                r.sig   = 1'b1;
                r.vcpu  = tbl_vcpu[p];
                r.token = tbl_token[p];
            end
        end else begin
            if (tbl_state[p] == PS_HOST)
                r.token = tbl_token[p];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [TOK_W-1:0] got,
                                   input logic [TOK_W-1:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    task automatic check_result_word(input logic [OUT_DW-1:0] w);
        t_port_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result word with nothing pending", TOK_W'(w[2:0]), '0);
            return;
        end
        want = expected_results.pop_front();
        if (w[2:0] != want.status)
            report_mismatch("status", TOK_W'(w[2:0]), TOK_W'(want.status));
        if (w[12:3] != want.port)
            report_mismatch("port_out", TOK_W'(w[12:3]), TOK_W'(want.port));
        if (w[13] != want.sig)
            report_mismatch("signal_valid", TOK_W'(w[13]), TOK_W'(want.sig));
        if (w[17:14] != want.vcpu)
            report_mismatch("signal_vcpu", TOK_W'(w[17:14]), TOK_W'(want.vcpu));
        if (w[81:18] != want.token)
            report_mismatch("token_out", w[81:18], want.token);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            expected_results.delete();
        end else begin
            // results first: a word leaving now never belongs to the one entering
            if (i_m_tvalid && i_m_tready)
                check_result_word(i_m_tdata);
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(run_port_command(i_s_tdata));
            if (i_cfg_wen)
                dying = i_cfg_wdata;
        end
        o_pending = expected_results.size();
    end

endmodule

// File: test/event_channel_port_table_tb.sv
`timescale 1ns / 1ps
// testbench top for event_channel_port_table: clock, reset, command stimulus and verdict
// depends on ecpt_pkg, the block itself and ecpt_result_checker
module event_channel_port_table_tb;
    import ecpt_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RST_CYCLES    = 10;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int LOW_PORT_POOL = 47;
    localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wen;
    logic              i_cfg_wdata;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [IN_DW-1:0]  i_s_tdata;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [OUT_DW-1:0] o_m_tdata;

    int error_count;
    int pending_count;
    int sender_idle_pct;
    int receiver_stall_pct;
    int quiet_cycles;
    bit hold_request;
    bit hold_served;

    event_channel_port_table i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    ecpt_result_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_errors    (error_count),
        .o_pending   (pending_count)
    );

    always begin
        i_clk = 1'b1;
        #HALF_PERIOD;
        i_clk = 1'b0;
        #HALF_PERIOD;
    end

    // no accepted word for too long means the block is stuck
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL event_channel_port_table");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls plus one long hold-off to back the block up
    initial begin
        i_m_tready = 1'b0;
        hold_served = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_served) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_served = 1;
            end
            i_m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic logic [DOM_W-1:0] pick_domain();
        // a small pool makes peer matches on bind likely
        if ($urandom_range(99) < 85)
            return DOM_W'($urandom_range(3));
        return DOM_W'($urandom);
    endfunction

    function automatic logic [PORT_W-1:0] pick_port();
        if ($urandom_range(99) < 85)
            return PORT_W'($urandom_range(LOW_PORT_POOL));
        return PORT_W'($urandom);
    endfunction

    function automatic logic [TOK_W-1:0] pick_token();
        if ($urandom_range(99) < 8)
            return '0;
        return {$urandom, $urandom};
    endfunction

    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port,
                                 input logic [VCPU_W-1:0] vcpu, input logic [DOM_W-1:0] rdom,
                                 input logic [DOM_W-1:0] cdom, input logic priv,
                                 input logic [TOK_W-1:0] tok);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, tok, priv, cdom, rdom, vcpu, port, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic random_command();
        int pick;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 22)
            cmd = CMD_ALLOC;
        else if (pick < 50)
            cmd = CMD_BIND;
        else if (pick < 62)
            cmd = CMD_FREE;
        else if (pick < 77)
            cmd = CMD_NOTIFY;
        else if (pick < 92)
            cmd = CMD_QUERY;
        else if (pick < 95)
            cmd = CMD_DESTROY;
        else
            cmd = $urandom_range(1) ? CMD_RSVD_7 : CMD_RSVD_6;
        issue_command(cmd, pick_port(), VCPU_W'($urandom), pick_domain(), pick_domain(),
                      $urandom_range(99) < 90, pick_token());
    endtask

    task automatic run_mixed(input int count);
        int n;
        for (n = 0; n < count; n++)
            random_command();
    endtask

    // mostly allocates, so the table fills and runs out of ports
    task automatic run_fill(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < 96)
                issue_command(CMD_ALLOC, PORT_W'($urandom), VCPU_W'($urandom),
                              DOM_W'($urandom), DOM_W'($urandom), 1'($urandom), {$urandom, $urandom});
            else
                issue_command($urandom_range(1) ? CMD_NOTIFY : CMD_QUERY, PORT_W'($urandom),
                              VCPU_W'($urandom), DOM_W'($urandom), DOM_W'($urandom), 1'b1,
                              {$urandom, $urandom});
        end
    endtask

    task automatic write_dying(input logic value);
        i_s_tvalid <= 1'b0;
        wait (pending_count == 0);
        @(negedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    initial begin
        i_rst_n            = 1'b0;
        i_cfg_wen          = 1'b0;
        i_cfg_wdata        = 1'b0;
        i_s_tvalid         = 1'b0;
        i_s_tdata          = '0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_request       = 0;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        write_dying(1'b0);

        // directed: error order on bind, owned checks, signal path, destroy
        issue_command(CMD_QUERY,   10'd0,    4'd0,  16'd0,     16'd0,     1'b1, 64'd5);
        issue_command(CMD_FREE,    10'd0,    4'd0,  16'd0,     16'd0,     1'b1, 64'd5);
        issue_command(CMD_ALLOC,   10'd0,    4'd15, 16'hFFFF,  16'd0,     1'b0, 64'd0);
        issue_command(CMD_ALLOC,   10'h3FF,  4'd0,  16'd0,     16'hFFFF,  1'b0, '1);
        issue_command(CMD_BIND,    10'd1,    4'd0,  16'd0,     16'hFFFF,  1'b1, 64'd0);
        issue_command(CMD_BIND,    10'd1,    4'd0,  16'd0,     16'hFFFF,  1'b0, 64'd7);
        issue_command(CMD_BIND,    10'd1,    4'd0,  16'd0,     16'd0,     1'b1, 64'd7);
        issue_command(CMD_BIND,    10'h3FF,  4'd0,  16'd0,     16'hFFFF,  1'b1, 64'd7);
        issue_command(CMD_NOTIFY,  10'd1,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_QUERY,   10'd1,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_BIND,    10'd1,    4'd0,  16'd0,     16'hFFFF,  1'b1, '1);
        issue_command(CMD_BIND,    10'd1,    4'd0,  16'd0,     16'hFFFF,  1'b1, 64'd9);
        issue_command(CMD_NOTIFY,  10'd1,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_QUERY,   10'd1,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_BIND,    10'd2,    4'd0,  16'd0,     16'd0,     1'b1, 64'd1);
        issue_command(CMD_FREE,    10'd2,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_FREE,    10'd2,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_RSVD_6,  10'd1,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_NOTIFY,  10'h3FF,  4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_DESTROY, 10'd0,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_QUERY,   10'd1,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);

        // dying: allocate rejected, the rest ignored, destroy still runs
        write_dying(1'b1);
        issue_command(CMD_ALLOC,   10'd0,    4'd3,  16'd1,     16'd1,     1'b1, 64'd1);
        issue_command(CMD_BIND,    10'd1,    4'd0,  16'd1,     16'd1,     1'b1, 64'd1);
        issue_command(CMD_NOTIFY,  10'd1,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_DESTROY, 10'd0,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        issue_command(CMD_RSVD_7,  10'd0,    4'd0,  16'd0,     16'd0,     1'b0, 64'd0);
        write_dying(1'b0);

        // back-to-back offers while the result side holds off
        hold_request = 1;
        run_mixed(200);

        sender_idle_pct = 83;
        run_mixed(150);

        write_dying(1'b1);
        sender_idle_pct    = 12;
        receiver_stall_pct = 12;
        run_mixed(100);
        write_dying(1'b0);

        sender_idle_pct    = 0;
        receiver_stall_pct = 83;
        run_mixed(150);

        receiver_stall_pct = 0;
        run_fill(1060);

        sender_idle_pct    = 12;
        receiver_stall_pct = 12;
        run_mixed(120);

        i_s_tvalid <= 1'b0;
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("PASS event_channel_port_table");
        else
            $display("FAIL event_channel_port_table");
        $finish;
    end

endmodule
